// ----- rtl/core/cli_pkg.sv -----
package cli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 7;
  localparam int IDX_W       = 6;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // queued command; pos carries the grid point of a load or the target of a query
  typedef struct packed {
    logic              is_query;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] pos;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo_grid;
    logic [DATA_W-1:0] hi_grid;
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] lo_value;
    logic [DATA_W-1:0] hi_value;
  } lerp_req_t;

endpackage

// ----- rtl/core/cli_ram.sv -----
module cli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/cli_front.sv -----
module cli_front
  import cli_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [DATA_W-1:0] grid_point,
  input  logic [DATA_W-1:0] point_value,
  input  logic [DATA_W-1:0] target,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic full;
  logic accept;
  logic in_range;
  logic push;
  logic pop;
  cmd_t entry;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign busy      = full;
  assign accept    = start && !full;
  assign in_range  = (32'(entry_index) < TABLE_DEPTH);
  // loads past the end of the table are dropped here
  assign push      = accept && ((opcode == OP_QUERY) || in_range);
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_comb begin
    entry.is_query = (opcode == OP_QUERY);
    entry.addr     = ADDR_W'(entry_index);
    entry.pos      = (opcode == OP_QUERY) ? target : grid_point;
    entry.value    = point_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/cli_lerp.sv -----
module cli_lerp
  import cli_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  lerp_req_t         req,
  output logic              done,
  output logic [DATA_W-1:0] result
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_FIX  = 4'b1000
  } lstate_t;

  lstate_t            state;
  logic [DATA_W-1:0]  span;
  logic [DATA_W-1:0]  offset;
  logic [DATA_W-1:0]  mag;
  logic               neg;
  logic [DATA_W-1:0]  lo_v;
  logic [DATA_W-1:0]  rem;
  logic [DATA_W-1:0]  quo;
  logic [DIV_CNT_W-1:0] cnt;

  logic [DATA_W-1:0] span_c;
  logic [DATA_W-1:0] dist_c;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   trial_sub;
  logic              ge;

  always_comb begin
    span_c = req.hi_grid - req.lo_grid;
    dist_c = (req.target > req.lo_grid) ? (req.target - req.lo_grid) : '0;
    if (dist_c > span_c) begin
      dist_c = span_c;
    end
  end

  // restoring division; rem stays below span so the quotient fits DATA_W bits
  assign trial     = {rem, quo[DATA_W-1]};
  assign trial_sub = trial - {1'b0, span};
  assign ge        = (trial >= {1'b0, span});

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (go) begin
          lo_v   <= req.lo_value;
          span   <= span_c;
          offset <= dist_c;
          neg    <= ($signed(req.hi_value) < $signed(req.lo_value));
          // magnitude of the value step always fits DATA_W bits unsigned
          mag    <= ($signed(req.hi_value) < $signed(req.lo_value)) ?
                    (req.lo_value - req.hi_value) : (req.hi_value - req.lo_value);
          if (req.hi_grid <= req.lo_grid) begin
            result <= req.lo_value;
          end
        end
      end
      L_MUL: begin
        {rem, quo} <= mag * offset;
      end
      L_DIV: begin
        rem <= ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], ge};
      end
      L_FIX: begin
        result <= neg ? (lo_v - quo) : (lo_v + quo);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (go) begin
            if (req.hi_grid <= req.lo_grid) begin
              done <= 1'b1;
            end else begin
              state <= L_MUL;
            end
          end
        end
        L_MUL: begin
          cnt   <= '0;
          state <= L_DIV;
        end
        L_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= L_FIX;
          end
        end
        L_FIX: begin
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/cli_back.sv -----
module cli_back
  import cli_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  entries_in_use,
  output logic              result_valid,
  output logic [DATA_W-1:0] interpolated_value
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIRST = 8'b0000_0010,
    S_LAST  = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_VLO   = 8'b0001_0000,
    S_VHI   = 8'b0010_0000,
    S_CLAMP = 8'b0100_0000,
    S_LERP  = 8'b1000_0000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [CFG_W-1:0]  active_entries;
  logic [DATA_W-1:0] tgt;
  logic [DATA_W-1:0] lo_g;
  logic [DATA_W-1:0] hi_g;
  logic [DATA_W-1:0] lo_v;
  logic [ADDR_W-1:0] idx;

  logic [CNT_W-1:0]  n_used;
  logic [ADDR_W-1:0] last_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] g_raddr;
  logic [ADDR_W-1:0] v_raddr;
  logic [DATA_W-1:0] g_rdata;
  logic [DATA_W-1:0] v_rdata;
  logic              lerp_go;
  logic              lerp_done;
  logic [DATA_W-1:0] lerp_result;
  lerp_req_t         lerp_req;
  logic              found;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_entries <= entries_in_use;
    end
  end

  // zero counts as one, anything past the table saturates
  always_comb begin
    if (active_entries == '0) begin
      n_used = CNT_W'(1);
    end else if (32'(active_entries) > TABLE_DEPTH) begin
      n_used = CNT_W'(TABLE_DEPTH);
    end else begin
      n_used = CNT_W'(active_entries);
    end
    last_addr = ADDR_W'(n_used - 1'b1);
  end

  cli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cmd.addr),
    .wdata (cmd.pos),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  cli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cmd.addr),
    .wdata (cmd.value),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  always_comb begin
    lerp_req.lo_grid  = lo_g;
    lerp_req.hi_grid  = hi_g;
    lerp_req.target   = tgt;
    lerp_req.lo_value = lo_v;
    lerp_req.hi_value = v_rdata;
  end

  cli_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .go     (lerp_go),
    .req    (lerp_req),
    .done   (lerp_done),
    .result (lerp_result)
  );

  // the scan stops at the last entry in use without testing it
  assign found = (g_rdata >= tgt) || (idx == last_addr);

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    g_raddr    = '0;
    v_raddr    = '0;
    lerp_go    = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_query) begin
            state_next = S_FIRST;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_FIRST: begin
        if (tgt <= g_rdata) begin
          state_next = S_CLAMP;
        end else begin
          g_raddr    = last_addr;
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (tgt >= g_rdata) begin
          v_raddr    = last_addr;
          state_next = S_CLAMP;
        end else begin
          g_raddr    = ADDR_W'(1);
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (found) begin
          v_raddr    = idx - 1'b1;
          state_next = S_VLO;
        end else begin
          g_raddr = idx + 1'b1;
        end
      end
      S_VLO: begin
        v_raddr    = idx;
        state_next = S_VHI;
      end
      S_VHI: begin
        lerp_go    = 1'b1;
        state_next = S_LERP;
      end
      S_CLAMP: begin
        state_next = S_IDLE;
      end
      S_LERP: begin
        if (lerp_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.is_query) begin
          tgt <= cmd.pos;
        end
      end
      S_FIRST: begin
        lo_g <= g_rdata;
      end
      S_LAST: begin
        idx <= ADDR_W'(1);
      end
      S_SCAN: begin
        if (found) begin
          hi_g <= g_rdata;
        end else begin
          lo_g <= g_rdata;
          idx  <= idx + 1'b1;
        end
      end
      S_VLO: begin
        lo_v <= v_rdata;
      end
      default: ;
    endcase
    if (state == S_CLAMP) begin
      interpolated_value <= v_rdata;
    end else if (state == S_LERP && lerp_done) begin
      interpolated_value <= lerp_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == S_CLAMP) || (state == S_LERP && lerp_done);
    end
  end

endmodule

// ----- rtl/core/clamped_linear_table_interpolator_top.sv -----
// Clamped piecewise-linear table interpolator.
// Command channel: an item is taken on a clock edge with start high and busy
// low. opcode selects a table load (entry_index, grid_point, point_value) or a
// query (target). Loads with an index past the table are dropped.
// Items go into a two-entry command queue; busy is high only while it is full.
// A load is written to the table by the back end and gives no result.
// A query gives one result: result_valid pulses for one cycle with
// interpolated_value. The receiver cannot stall; each result is taken in its
// strobe cycle. A query clamped at the low end is settled by the first grid
// read, one clamped at the high end by a read of the last entry in use; an
// interior query runs a linear scan with one grid memory read per entry up to
// the upper bracketing entry, then a multiply step and a 32-step restoring
// divider (both skipped when the two bracketing points are equal). A queued
// item waits for the one ahead of it.
// Configuration: entries_in_use is written through cfg_valid/cfg_ready
// (always ready); the user must write it only while the block is idle, which
// the block itself does not enforce. Reset (rst, synchronous)
// empties the queue, returns the sequencer to idle and sets entries_in_use to
// 64. Table contents are not cleared and must be loaded before any query.
module clamped_linear_table_interpolator_top
  import cli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic [DATA_W-1:0]        grid_point,
  input  logic signed [DATA_W-1:0] point_value,
  input  logic [DATA_W-1:0]        target,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         entries_in_use,
  output logic                     result_valid,
  output logic signed [DATA_W-1:0] interpolated_value
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  cli_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .entry_index (entry_index),
    .grid_point  (grid_point),
    .point_value (point_value),
    .target      (target),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  cli_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .entries_in_use     (entries_in_use),
    .result_valid       (result_valid),
    .interpolated_value (interpolated_value)
  );

endmodule

// ----- rtl/core/cli_checker.sv -----
module cli_checker
  import cli_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);

  // every query needs several memory reads, so strobes never abut
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("two result strobes in a row");

  a_reset_not_busy: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("busy right after reset");

  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result strobe right after reset");

  // the queue only fills through a transfer on the command channel
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

endmodule

bind clamped_linear_table_interpolator_top cli_checker u_cli_checker (.*);

// ----- tb/sv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cli_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 120;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 145;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_LOAD;
  logic [IDX_W-1:0] entry_index = '0;
  logic [DATA_W-1:0] grid_point = '0;
  logic signed [DATA_W-1:0] point_value = '0;
  logic [DATA_W-1:0] target = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] entries_in_use = CFG_RESET;
  logic result_valid;
  logic signed [DATA_W-1:0] interpolated_value;

  clamped_linear_table_interpolator_top u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .opcode             (opcode),
    .entry_index        (entry_index),
    .grid_point         (grid_point),
    .point_value        (point_value),
    .target             (target),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .entries_in_use     (entries_in_use),
    .result_valid       (result_valid),
    .interpolated_value (interpolated_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the breakpoint table and the entry count
  logic [DATA_W-1:0] grid_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] value_mem [TABLE_DEPTH];
  logic [CFG_W-1:0] active_entries = CFG_RESET;

  logic [DATA_W-1:0] expected_values [$];
  int errors = 0;
  int cycles = 0;
  int sender_idle = 0;

  typedef struct packed {
    logic              set_cfg;
    logic [CFG_W-1:0]  cfg;
    opcode_t           op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] grid;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] tgt;
    logic              typed;
    logic [DATA_W-1:0] known;
  } vec_row_t;

  localparam int DIR_ROWS = 21;
  vec_row_t dir_rows [DIR_ROWS] = '{
    '{1'b1, 7'd4, OP_LOAD, 6'd0, 32'h0100_0000, 32'h4000_0000, 32'h0, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_LOAD, 6'd1, 32'h0200_0000, 32'hC000_0000, 32'h0, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_LOAD, 6'd2, 32'h0400_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_LOAD, 6'd3, 32'hFF00_0000, 32'h8000_0000, 32'h0, 1'b0, 32'h0},
    // clamped at both ends
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_0000, 1'b1, 32'h4000_0000},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0100_0000, 1'b1, 32'h4000_0000},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'hFF00_0000, 1'b1, 32'h8000_0000},
    // interior points, exact breakpoints and one off the edges
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0180_0000, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0200_0000, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0300_0000, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0400_0001, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'hFEFF_FFFF, 1'b0, 32'h0},
    // entry 1 drops below entry 0: non-ascending table
    '{1'b0, 7'd0, OP_LOAD, 6'd1, 32'h0050_0000, 32'h0000_0000, 32'h0, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0180_0000, 1'b0, 32'h0},
    '{1'b0, 7'd0, OP_LOAD, 6'd63, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0},
    // count of zero acts as one
    '{1'b1, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h4000_0000},
    '{1'b0, 7'd0, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h0000_0000, 1'b1, 32'h4000_0000},
    // count past the table saturates; then full and single-entry counts
    '{1'b1, 7'd127, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{1'b1, 7'd64, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h8000_0000, 1'b0, 32'h0},
    '{1'b1, 7'd1, OP_QUERY, 6'd0, 32'h0, 32'h0, 32'h1234_5678, 1'b1, 32'h4000_0000}
  };

  function automatic int active_count();
    if (active_entries < 1) return 1;
    if (active_entries > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(active_entries);
  endfunction

  function automatic logic [DATA_W-1:0] interp_expected(logic [DATA_W-1:0] t);
    int n;
    int i;
    logic [DATA_W-1:0] lo_g;
    logic [DATA_W-1:0] hi_g;
    logic signed [DATA_W:0] lo_v;
    logic signed [DATA_W:0] hi_v;
    logic signed [DATA_W:0] diff;
    logic [63:0] span;
    logic [63:0] offset;
    logic [63:0] mag;
    logic [63:0] q;
    logic signed [DATA_W+1:0] res;
    n = active_count();
    if (t <= grid_mem[0]) return value_mem[0];
    if (t >= grid_mem[n-1]) return value_mem[n-1];
    i = 1;
    while (i < n - 1 && grid_mem[i] < t) i++;
    lo_g = grid_mem[i-1];
    hi_g = grid_mem[i];
    lo_v = value_mem[i-1];
    hi_v = value_mem[i];
    if (hi_g <= lo_g) return value_mem[i-1];
    span = 64'(hi_g - lo_g);
    offset = (t > lo_g) ? 64'(t - lo_g) : 64'd0;
    if (offset > span) offset = span;
    diff = hi_v - lo_v;
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    // exact product, truncating divide: magnitude never exceeds the value step
    q = (mag * offset) / span;
    if (diff < 0) res = lo_v - signed'({1'b0, q[32:0]});
    else res = lo_v + signed'({1'b0, q[32:0]});
    return res[DATA_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                 logic [DATA_W-1:0] got);
    $display("mismatch: %s expected %h got %h (cycle %0d)", what, want, got, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    logic [DATA_W-1:0] want;
    if (!rst && result_valid) begin
      if (expected_values.size() == 0) begin
        report_mismatch("result with nothing pending", 'x, interpolated_value);
      end else begin
        want = expected_values.pop_front();
        if (interpolated_value !== want)
          report_mismatch("interpolated_value", want, interpolated_value);
      end
    end
  end

  // drop start, wait out all pending queries and the back end's last load
  task automatic settle_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(logic [CFG_W-1:0] val);
    settle_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    entries_in_use <= val;
    do @(posedge clk); while (!cfg_ready);
    active_entries = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(opcode_t op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] g,
                           logic [DATA_W-1:0] v, logic [DATA_W-1:0] t,
                           logic typed, logic [DATA_W-1:0] known);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    entry_index <= idx;
    grid_point <= g;
    point_value <= v;
    target <= t;
    do @(posedge clk); while (busy);
    // transfer taken at this edge
    if (op == OP_LOAD) begin
      grid_mem[idx] = g;
      value_mem[idx] = v;
    end else begin
      expected_values.push_back(typed ? known : interp_expected(t));
    end
  endtask

  // ascending breakpoints over entries 0..n-1, with an occasional repeated point
  task automatic load_ascending(int n);
    logic [DATA_W-1:0] g;
    logic [DATA_W-1:0] step_max;
    logic [DATA_W-1:0] v;
    g = $urandom >> $urandom_range(1, 31);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0000;
        default: v = $urandom;
      endcase
      send_item(OP_LOAD, IDX_W'(i), g, v, $urandom, 1'b0, '0);
      step_max = (32'hFFFF_FFFF - g) / (n - i);
      if ($urandom_range(0, 3) == 0) step_max = step_max >> $urandom_range(0, 20);
      if (step_max == 0) step_max = 1;
      if ($urandom_range(0, 15) != 0) g = g + $urandom_range(1, step_max);
    end
  endtask

  int phase_cfg [PHASES] = '{64, 1, 2, 127, 0, 3, 17, 64, 9, 40};
  int idle_pcts [4] = '{0, 67, 0, 22};

  initial begin
    int n;
    int sent;
    int pick;
    int k;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every entry gets written before the first query
    load_ascending(TABLE_DEPTH);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].set_cfg) write_entry_count(dir_rows[r].cfg);
      send_item(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].grid, dir_rows[r].value,
                dir_rows[r].tgt, dir_rows[r].typed, dir_rows[r].known);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_entry_count(CFG_W'(phase_cfg[p]));
      sender_idle = idle_pcts[p % 4];
      n = active_count();
      load_ascending(n);
      sent = n;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) settle_idle();
        if ($urandom_range(0, 99) < 70) begin
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            t = $urandom_range(grid_mem[0], grid_mem[n-1]);
          end else if (pick < 75) begin
            k = $urandom_range(0, n - 1);
            t = grid_mem[k] + $urandom_range(0, 2) - 1;
          end else if (pick < 90) begin
            t = $urandom;
          end else begin
            t = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          end
          send_item(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, t, 1'b0, '0);
        end else if ($urandom_range(0, 9) < 7) begin
          // keeps the used part of the table in order
          k = $urandom_range(0, n - 1);
          lo = (k > 0) ? grid_mem[k-1] : 32'h0;
          hi = (k < n - 1) ? grid_mem[k+1] : 32'hFFFF_FFFF;
          send_item(OP_LOAD, IDX_W'(k), $urandom_range(lo, hi), $urandom, $urandom,
                    1'b0, '0);
        end else begin
          send_item(OP_LOAD, IDX_W'($urandom), $urandom, $urandom, $urandom, 1'b0, '0);
        end
        sent++;
      end
    end

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
